FILE: hw/rtl/tdpt_pkg.sv
// Shared types for the trial division prime test.
// Holds the controller state encoding and the divider status bundle.
// No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_FINISH
  } tdpt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tdpt_div_status_t;

endpackage

FILE: hw/rtl/tdpt_div_serial.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// The dividend shifts out MSB first while quotient bits shift in.
// Depends on tdpt_pkg for the status bundle.
`timescale 1ns / 1ps

module tdpt_div_serial #(
  parameter int WIDTH = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [WIDTH-1:0]          dividend,
  input  logic [WIDTH-1:0]          divisor,
  output tdpt_pkg::tdpt_div_status_t status,
  output logic [WIDTH-1:0]          quotient,
  output logic [WIDTH-1:0]          remainder
);
  import tdpt_pkg::*;

  localparam int CNT_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [WIDTH-1:0]    shreg;
  logic [WIDTH-1:0]    rem;
  logic [WIDTH-1:0]    quo;

  logic [WIDTH:0]      partial;
  logic [WIDTH:0]      diff;
  logic                ge;
  logic [WIDTH-1:0]    rem_next;

  // The divisor must stay stable while busy; the controller holds it.
  always_comb begin
    partial  = {rem, shreg[WIDTH-1]};
    ge       = (partial >= {1'b0, divisor});
    diff     = partial - {1'b0, divisor};
    rem_next = ge ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      shreg <= {shreg[WIDTH-2:0], 1'b0};
      rem   <= rem_next;
      quo   <= {quo[WIDTH-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rem;

endmodule

FILE: hw/rtl/trial_division_prime_test.sv
// Trial division prime test. Values below 2 and even values skip the divider.
// Odd values try divisors 3, 5, 7, ... each a full pass of the bit-serial divider,
// until one divides the value or passes its square root. One value is in work
// at a time; a finished result waits in the output register while the next value
// is taken.
// Synchronous active-high reset returns to idle with no result pending.
`timescale 1ns / 1ps

module trial_division_prime_test #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_prime
);
  import tdpt_pkg::*;

  tdpt_state_t      state, state_next;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] d, d_next;
  logic             result, result_next;
  logic             out_valid_next;
  logic             is_prime_next;
  logic             div_start;
  logic             load_v;

  tdpt_div_status_t      div_status;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] rem;

  tdpt_div_serial #(
    .WIDTH(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (load_v ? value : v),
    .divisor   (d_next),
    .status    (div_status),
    .quotient  (quo),
    .remainder (rem)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    d_next         = d;
    result_next    = result;
    out_valid_next = out_valid;
    is_prime_next  = is_prime;
    div_start      = 1'b0;
    load_v         = 1'b0;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          load_v = 1'b1;
          if (value[VALUE_BITS-1:1] == '0) begin
            result_next = 1'b0;
            state_next  = S_FINISH;
          end else if (!value[0]) begin
            result_next = (value == VALUE_BITS'(2));
            state_next  = S_FINISH;
          end else begin
            d_next     = VALUE_BITS'(3);
            div_start  = 1'b1;
            state_next = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        if (div_status.done) begin
          // Past the square root with no divisor found: prime.
          if (d > quo) begin
            result_next = 1'b1;
            state_next  = S_FINISH;
          end else if (rem == '0) begin
            result_next = 1'b0;
            state_next  = S_FINISH;
          end else begin
            d_next    = d + VALUE_BITS'(2);
            div_start = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          is_prime_next  = result;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_v) begin
      v <= value;
    end
    d        <= d_next;
    result   <= result_next;
    is_prime <= is_prime_next;
  end

endmodule
